### design/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Types, codes and constants for the EDF slack task scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int IDX_W      = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  localparam logic [7:0]  PRIO_IDLE  = 8'd0;
  localparam logic [7:0]  PRIO_LOW   = 8'd1;
  localparam logic [7:0]  PRIO_TOP   = 8'd255;
  localparam logic [31:0] SLACK_NONE = 32'h7FFF_FFFF;

  localparam logic [1:0] MODE_READY   = 2'd0;
  localparam logic [1:0] MODE_BLOCKED = 2'd2;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_CREATE   = 3'd1;
  localparam logic [2:0] OP_SETPRIO  = 3'd2;
  localparam logic [2:0] OP_OVERRIDE = 3'd3;
  localparam logic [2:0] OP_DISPATCH = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;
  // unassigned codes, answered with an empty beat
  localparam logic [2:0] OP_SPARE6   = 3'd6;
  localparam logic [2:0] OP_SPARE7   = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  task_index;
    logic [31:0] period;
    logic [30:0] deadline;
    logic [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  chosen_task;
    logic        chosen_valid;
    logic signed [31:0] chosen_slack;
    logic [31:0] run_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // per-slot status handed from sequencer to scan unit
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  prio;
    logic [31:0] slack;
  } slot_view_t;

  // scan unit result
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] win;
    logic [31:0]      best_slack;
    logic [7:0]       best_prio;
  } scan_t;

endpackage

### design/edf_slack_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// edf_slack_task_scheduler_top
// EDF scheduler with slack boost over a table of TASK_SLOTS periodic tasks.
// ----------------------------------------------------------------------------
// Flow: tick and dispatch walk the table in ST_SCAN, one slot per cycle through the
// shared compare unit, then pick in ST_FINISH and set out_valid from ST_OUT; clear
// walks the table in ST_CLEAR before ST_OUT; the other ops and a locked tick go to ST_OUT.
// One item at a time; in_ready low while an item is at work or its result waits,
// so the next beat is taken the cycle after the result beat leaves.
// Reset (synchronous, rst_n low) empties time, count and lock, then a clearing pass
// in ST_CLEAR zeroes the table with in_ready low and no result beat.
module edf_slack_task_scheduler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  edf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output edf_pkg::out_item_t  out_data
);

  localparam int N = edf_pkg::TASK_SLOTS;
  localparam int IW = edf_pkg::IDX_W;

  logic [31:0] per_r [N];
  logic [30:0] dl_r  [N];
  logic [31:0] rel_r [N];
  logic [31:0] slk_r [N];
  logic [7:0]  pri_r [N];
  logic [1:0]  mode_r[N];
  logic [31:0] runs_r[N];

  logic [31:0] now_r;
  logic        lock_r;
  logic [edf_pkg::CNT_W-1:0] cnt_r;

  edf_pkg::state_t   st_r, st_nxt;
  edf_pkg::in_item_t item_r;
  logic [IW:0]       ptr_r;
  edf_pkg::out_item_t od_r;
  logic              ov_r;
  logic              init_r;

  wire accept = in_valid && in_ready;
  wire [IW-1:0] pi = ptr_r[IW-1:0];
  wire ptr_in = ({{(32-IW-1){1'b0}}, ptr_r} < {{(32-edf_pkg::CNT_W){1'b0}}, cnt_r});
  wire ptr_end = (ptr_r == (IW+1)'(N));

  // per-slot tick update, computed for the slot under the pointer
  logic        rel_due;
  logic [31:0] rel_new;
  logic [1:0]  mode_new;
  logic [31:0] slk_new;
  edf_pkg::slot_view_t view;
  edf_pkg::scan_t      sres;
  logic scan_start, scan_step, by_prio;

  always_comb begin
    rel_due  = (now_r - rel_r[pi]) >= per_r[pi];
    rel_new  = rel_due ? now_r : rel_r[pi];
    mode_new = rel_due ? edf_pkg::MODE_READY : mode_r[pi];
    slk_new  = {1'b0, dl_r[pi]} - (now_r - rel_new);
    if (by_prio) begin
      view.mode  = mode_r[pi];
      view.prio  = pri_r[pi];
      view.slack = slk_r[pi];
    end else begin
      view.mode  = mode_new;
      view.prio  = pri_r[pi];
      view.slack = slk_new;
    end
  end

  assign by_prio    = (item_r.op == edf_pkg::OP_DISPATCH);
  assign scan_start = accept;
  assign scan_step  = (st_r == edf_pkg::ST_SCAN) && ptr_in && !ptr_end;

  edf_scan u_scan (
    .clk(clk), .rst_n(rst_n), .start(scan_start), .step(scan_step),
    .by_prio(by_prio), .idx(pi), .view(view), .res(sres)
  );

  assign in_ready  = (st_r == edf_pkg::ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      edf_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.op)
            edf_pkg::OP_TICK: st_nxt = lock_r ? edf_pkg::ST_OUT : edf_pkg::ST_SCAN;
            edf_pkg::OP_DISPATCH: st_nxt = edf_pkg::ST_SCAN;
            edf_pkg::OP_CLEAR: st_nxt = edf_pkg::ST_CLEAR;
            default: st_nxt = edf_pkg::ST_OUT;
          endcase
        end
      end
      edf_pkg::ST_SCAN:   if (ptr_end) st_nxt = edf_pkg::ST_FINISH;
      edf_pkg::ST_FINISH: st_nxt = edf_pkg::ST_OUT;
      edf_pkg::ST_CLEAR:  if (ptr_end) st_nxt = init_r ? edf_pkg::ST_IDLE : edf_pkg::ST_OUT;
      edf_pkg::ST_OUT:    st_nxt = edf_pkg::ST_IDLE;
      default:            st_nxt = edf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= edf_pkg::ST_CLEAR;
      ptr_r <= '0;
      ov_r <= 1'b0;
      init_r <= 1'b1;
      now_r <= '0;
      lock_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        edf_pkg::ST_IDLE: begin
          ptr_r <= '0;
          if (accept) begin
            item_r <= in_data;
            if ((in_data.op == edf_pkg::OP_CREATE) && (cnt_r < edf_pkg::CNT_W'(N))) begin
              od_r <= '{chosen_task: 3'(cnt_r), chosen_valid: 1'b1,
                        chosen_slack: {1'b0, in_data.deadline}, run_count: 32'd0};
            end else begin
              od_r <= '0;
            end
            case (in_data.op)
              edf_pkg::OP_TICK: now_r <= now_r + 32'd1;
              edf_pkg::OP_CREATE: begin
                if (cnt_r < edf_pkg::CNT_W'(N)) begin
                  per_r[cnt_r[IW-1:0]]  <= in_data.period;
                  dl_r[cnt_r[IW-1:0]]   <= in_data.deadline;
                  rel_r[cnt_r[IW-1:0]]  <= '0;
                  slk_r[cnt_r[IW-1:0]]  <= {1'b0, in_data.deadline};
                  pri_r[cnt_r[IW-1:0]]  <= edf_pkg::PRIO_LOW;
                  mode_r[cnt_r[IW-1:0]] <= edf_pkg::MODE_READY;
                  runs_r[cnt_r[IW-1:0]] <= '0;
                  cnt_r <= cnt_r + 1'b1;
                end
              end
              edf_pkg::OP_SETPRIO: begin
                if ({1'b0, in_data.task_index} < 4'(cnt_r))
                  pri_r[in_data.task_index[IW-1:0]] <= in_data.priority_req;
              end
              edf_pkg::OP_OVERRIDE: begin
                lock_r <= 1'b1;
                for (int i = 0; i < N; i++) begin
                  if (i < int'(cnt_r)) begin
                    if (in_data.task_index == 3'(i)) begin
                      pri_r[i]  <= edf_pkg::PRIO_TOP;
                      mode_r[i] <= edf_pkg::MODE_READY;
                    end else begin
                      pri_r[i] <= edf_pkg::PRIO_IDLE;
                    end
                  end
                end
              end
              edf_pkg::OP_CLEAR: begin
                now_r <= '0;
                lock_r <= 1'b0;
                cnt_r <= '0;
              end
              default: ;
            endcase
          end
        end
        edf_pkg::ST_SCAN: begin
          if (!ptr_end) begin
            ptr_r <= ptr_r + 1'b1;
            if (ptr_in && !by_prio) begin
              rel_r[pi] <= rel_new;
              mode_r[pi] <= mode_new;
              if (mode_new == edf_pkg::MODE_READY) begin
                slk_r[pi] <= slk_new;
                pri_r[pi] <= edf_pkg::PRIO_LOW;
              end
            end
          end
        end
        edf_pkg::ST_FINISH: begin
          if (sres.found) begin
            od_r <= '{chosen_task: 3'(sres.win), chosen_valid: 1'b1,
                      chosen_slack: slk_r[sres.win],
                      run_count: by_prio ? runs_r[sres.win] + 32'd1 : 32'd0};
            if (by_prio) begin
              runs_r[sres.win] <= runs_r[sres.win] + 32'd1;
              mode_r[sres.win] <= edf_pkg::MODE_BLOCKED;
            end else begin
              pri_r[sres.win] <= edf_pkg::PRIO_TOP;
            end
          end
        end
        edf_pkg::ST_CLEAR: begin
          // one slot a cycle; after reset the final beat is suppressed
          if (!ptr_end) begin
            ptr_r <= ptr_r + 1'b1;
            per_r[pi] <= '0; dl_r[pi] <= '0; rel_r[pi] <= '0; slk_r[pi] <= '0;
            pri_r[pi] <= '0; mode_r[pi] <= edf_pkg::MODE_READY; runs_r[pi] <= '0;
          end else begin
            init_r <= 1'b0;
          end
        end
        edf_pkg::ST_OUT: begin
          ov_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // a result beat only leaves while nothing new is being taken
  assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> !in_ready)
    else $error("input accepted with result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == edf_pkg::ST_SCAN) |-> (ptr_r <= (IW+1)'(N)))
    else $error("scan pointer overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= edf_pkg::CNT_W'(N)))
    else $error("task count overflow");

endmodule

### design/edf_scan.sv
// ----------------------------------------------------------------------------
// edf_scan
// Shared compare unit: tracks the running best over one slot per cycle.
// Tick mode keeps the smallest signed slack, dispatch the largest priority.
// ----------------------------------------------------------------------------
module edf_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     step,
  input  logic                     by_prio,
  input  logic [edf_pkg::IDX_W-1:0] idx,
  input  edf_pkg::slot_view_t      view,
  output edf_pkg::scan_t           res
);

  edf_pkg::scan_t res_r, res_nxt;
  logic better;

  always_comb begin
    if (by_prio) begin
      better = (view.mode == edf_pkg::MODE_READY) && (view.prio > res_r.best_prio);
    end else begin
      better = (view.mode == edf_pkg::MODE_READY) &&
               ($signed(view.slack) < $signed(res_r.best_slack));
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (start) begin
      res_nxt.found      = 1'b0;
      res_nxt.win        = '0;
      res_nxt.best_slack = edf_pkg::SLACK_NONE;
      res_nxt.best_prio  = edf_pkg::PRIO_IDLE;
    end else if (step && better) begin
      res_nxt.found      = 1'b1;
      res_nxt.win        = idx;
      res_nxt.best_slack = view.slack;
      res_nxt.best_prio  = view.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.found <= 1'b0;
      res_r.win   <= '0;
    end else begin
      res_r.found <= res_nxt.found;
      res_r.win   <= res_nxt.win;
    end
    res_r.best_slack <= res_nxt.best_slack;
    res_r.best_prio  <= res_nxt.best_prio;
  end

  assign res = res_r;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the EDF slack scheduler against a behavioral model of its task table
// across directed op sequences, random op mixes (spare codes included) and back-pressure.
// ----------------------------------------------------------------------------
module testbench;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  edf_pkg::in_item_t   in_data;
  logic                out_valid;
  logic                out_ready;
  edf_pkg::out_item_t  out_data;

  edf_slack_task_scheduler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // scheduler model state
  logic [31:0] m_now;
  logic        m_lock;
  int unsigned m_count;
  logic [31:0] m_period [edf_pkg::TASK_SLOTS];
  logic [30:0] m_deadline [edf_pkg::TASK_SLOTS];
  logic [31:0] m_release [edf_pkg::TASK_SLOTS];
  logic [31:0] m_slack [edf_pkg::TASK_SLOTS];
  logic [7:0]  m_prio [edf_pkg::TASK_SLOTS];
  logic [1:0]  m_mode [edf_pkg::TASK_SLOTS];
  logic [31:0] m_runs [edf_pkg::TASK_SLOTS];

  edf_pkg::out_item_t pending_results [$];
  int          errors;
  int          mismatches;
  bit          hold_off;
  bit          sink_busy;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void model_clear();
    m_now = '0;
    m_lock = 0;
    m_count = 0;
    for (int i = 0; i < edf_pkg::TASK_SLOTS; i++) begin
      m_period[i] = '0; m_deadline[i] = '0; m_release[i] = '0;
      m_slack[i] = '0; m_prio[i] = '0; m_mode[i] = edf_pkg::MODE_READY; m_runs[i] = '0;
    end
  endfunction

  function automatic edf_pkg::out_item_t schedule_step(edf_pkg::in_item_t it);
    edf_pkg::out_item_t r;
    bit          found;
    int unsigned win;
    logic signed [31:0] best;
    logic [7:0]  maxp;
    r = '0;
    found = 0;
    win = 0;
    case (it.op)
      edf_pkg::OP_TICK: begin
        m_now = m_now + 32'd1;
        if (!m_lock) begin
          best = edf_pkg::SLACK_NONE;
          for (int i = 0; i < m_count; i++) begin
            if (32'(m_now - m_release[i]) >= m_period[i]) begin
              m_release[i] = m_now;
              m_mode[i] = edf_pkg::MODE_READY;
            end
            if (m_mode[i] == edf_pkg::MODE_READY) begin
              m_slack[i] = {1'b0, m_deadline[i]} - 32'(m_now - m_release[i]);
              if ($signed(m_slack[i]) < best) begin
                best = $signed(m_slack[i]);
                win = i;
                found = 1;
              end
              m_prio[i] = edf_pkg::PRIO_LOW;
            end
          end
          if (found) begin
            m_prio[win] = edf_pkg::PRIO_TOP;
            r.chosen_task = win[2:0];
            r.chosen_valid = 1;
            r.chosen_slack = m_slack[win];
          end
        end
      end
      edf_pkg::OP_CREATE: begin
        if (m_count < edf_pkg::TASK_SLOTS) begin
          m_period[m_count] = it.period;
          m_deadline[m_count] = it.deadline;
          m_release[m_count] = '0;
          m_slack[m_count] = {1'b0, it.deadline};
          m_prio[m_count] = edf_pkg::PRIO_LOW;
          m_mode[m_count] = edf_pkg::MODE_READY;
          m_runs[m_count] = '0;
          r.chosen_task = m_count[2:0];
          r.chosen_valid = 1;
          r.chosen_slack = {1'b0, it.deadline};
          m_count++;
        end
      end
      edf_pkg::OP_SETPRIO:
        if (it.task_index < m_count) m_prio[it.task_index] = it.priority_req;
      edf_pkg::OP_OVERRIDE: begin
        m_lock = 1;
        for (int i = 0; i < m_count; i++) begin
          if (i == it.task_index) begin
            m_prio[i] = edf_pkg::PRIO_TOP;
            m_mode[i] = edf_pkg::MODE_READY;
          end else begin
            m_prio[i] = edf_pkg::PRIO_IDLE;
          end
        end
      end
      edf_pkg::OP_DISPATCH: begin
        maxp = edf_pkg::PRIO_IDLE;
        for (int i = 0; i < m_count; i++) begin
          if (m_mode[i] == edf_pkg::MODE_READY && m_prio[i] > maxp) begin
            maxp = m_prio[i];
            win = i;
            found = 1;
          end
        end
        if (found) begin
          m_runs[win] = m_runs[win] + 32'd1;
          m_mode[win] = edf_pkg::MODE_BLOCKED;
          r.chosen_task = win[2:0];
          r.chosen_valid = 1;
          r.chosen_slack = m_slack[win];
          r.run_count = m_runs[win];
        end
      end
      edf_pkg::OP_CLEAR: model_clear();
      default: ;
    endcase
    return r;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) :
           ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
  endfunction

  task automatic send_item(edf_pkg::in_item_t it);
    int gap;
    gap = short_gap();
    repeat (gap) @(negedge clk);
    in_valid = 1;
    in_data = it;
    pending_results.push_back(schedule_step(it));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic send_op(logic [2:0] op, logic [2:0] idx = '0, logic [31:0] per = '0,
                         logic [30:0] dl = '0, logic [7:0] pr = '0);
    edf_pkg::in_item_t it;
    it.op = op; it.task_index = idx; it.period = per;
    it.deadline = dl; it.priority_req = pr;
    send_item(it);
  endtask

  function automatic edf_pkg::in_item_t random_item();
    edf_pkg::in_item_t it;
    int sel;
    it.op = 3'($urandom_range(0, 7));
    it.task_index = 3'($urandom_range(0, 7));
    it.period = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 12);
    it.deadline = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 20));
    it.priority_req = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 40) it.op = edf_pkg::OP_TICK;
    else if (sel < 55) it.op = edf_pkg::OP_DISPATCH;
    else if (sel < 65) it.op = edf_pkg::OP_CREATE;
    else if (sel < 75) it.op = edf_pkg::OP_SETPRIO;
    else if (sel < 77) it.op = edf_pkg::OP_OVERRIDE;
    else if (sel < 80) it.op = edf_pkg::OP_CLEAR;
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    edf_pkg::out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result beat %p", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.chosen_task !== exp_r.chosen_task ||
            out_data.chosen_valid !== exp_r.chosen_valid ||
            out_data.chosen_slack !== exp_r.chosen_slack ||
            out_data.run_count !== exp_r.run_count) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch: exp task=%0d v=%0b slack=%0d runs=%0d",
                      " got task=%0d v=%0b slack=%0d runs=%0d"},
                     exp_r.chosen_task, exp_r.chosen_valid, exp_r.chosen_slack,
                     exp_r.run_count, out_data.chosen_task, out_data.chosen_valid,
                     out_data.chosen_slack, out_data.run_count);
        end
      end
    end
  end

  // receiver stalls; hold_off forces a long back-pressure stretch
  initial begin
    int n;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        sink_busy = 1;
        repeat (300) @(negedge clk);
        sink_busy = 0;
        hold_off = 0;
      end else begin
        n = short_gap();
        if (n == 0 || $urandom_range(0, 3) == 0) out_ready <= 1;
        else begin
          out_ready <= 0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic test_create_and_full();
    send_op(edf_pkg::OP_CREATE, 3'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_op(edf_pkg::OP_CREATE, 3'd0, 32'd0, 31'd0);
    for (int i = 0; i < 7; i++) send_op(edf_pkg::OP_CREATE, 3'd0, 32'(i + 1), 31'(i * 3));
    send_op(edf_pkg::OP_DISPATCH);
  endtask

  task automatic test_tick_and_dispatch();
    for (int i = 0; i < 4; i++) send_op(edf_pkg::OP_TICK);
    send_op(edf_pkg::OP_SETPRIO, 3'd7, 32'd0, 31'd0, 8'hFF);
    send_op(edf_pkg::OP_SETPRIO, 3'd2, 32'd0, 31'd0, 8'h00);
    send_op(edf_pkg::OP_DISPATCH);
    send_op(edf_pkg::OP_DISPATCH);
    send_op(edf_pkg::OP_SPARE6);
    send_op(edf_pkg::OP_SPARE7, 3'd7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
  endtask

  task automatic test_override_and_range();
    send_op(edf_pkg::OP_CLEAR);
    send_op(edf_pkg::OP_CREATE, 3'd0, 32'd2, 31'd5);
    send_op(edf_pkg::OP_SETPRIO, 3'd5, 32'd0, 31'd0, 8'h55);
    send_op(edf_pkg::OP_OVERRIDE, 3'd6);
    send_op(edf_pkg::OP_TICK);
    send_op(edf_pkg::OP_DISPATCH);
    send_op(edf_pkg::OP_OVERRIDE, 3'd0);
    send_op(edf_pkg::OP_DISPATCH);
    send_op(edf_pkg::OP_CLEAR);
    send_op(edf_pkg::OP_TICK);
    send_op(edf_pkg::OP_DISPATCH);
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    @(negedge clk);
    for (int i = 0; i < 20; i++) send_item(random_item());
  endtask

  task automatic test_random();
    for (int i = 0; i < 1900; i++) send_item(random_item());
  endtask

  initial begin
    int waited;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    hold_off = 0;
    sink_busy = 0;
    errors = 0;
    mismatches = 0;
    model_clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_create_and_full();
    test_tick_and_dispatch();
    test_override_and_range();
    test_backpressure();
    test_random();
    waited = 0;
    while ((pending_results.size() != 0 || sink_busy) && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (edf_pkg::TASK_SLOTS + 20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/edf_pkg.sv
design/edf_scan.sv
design/edf_slack_task_scheduler_top.sv
dv/testbench.sv
